// ===== design/pgg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_pkg: shared types and constants
// Payload structs, sequencer states, register indexes and CORDIC helpers.
// ----------------------------------------------------------------------------
package pgg_pkg;

  typedef struct packed {
    logic               opcode;
    logic [31:0]        time_ms;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic               loc_mode;
    logic               loc_matched;
    logic [7:0]         loss_cnt;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         start_cell_x;
    logic [8:0]         start_cell_y;
    logic [8:0]         goal_cell_x;
    logic [8:0]         goal_cell_y;
    logic signed [31:0] goal_world_x;
    logic signed [31:0] goal_world_y;
    logic signed [15:0] goal_heading;
    logic               goal_absolute;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    CFG_CPM    = 4'd0,
    CFG_ORG_X  = 4'd1,
    CFG_ORG_Y  = 4'd2,
    CFG_GOAL_X = 4'd3,
    CFG_GOAL_Y = 4'd4,
    CFG_ABS_H  = 4'd5,
    CFG_MODE   = 4'd6,
    CFG_INTVL  = 4'd7
  } cfg_idx_t;

  // Multiply operations run by the sequencer, in order.
  typedef enum logic [2:0] {
    OP_CF  = 3'd0,
    OP_SL  = 3'd1,
    OP_SF  = 3'd2,
    OP_CL  = 3'd3,
    OP_SX  = 3'd4,
    OP_SY  = 3'd5,
    OP_GX  = 3'd6,
    OP_GY  = 3'd7
  } mul_op_t;

  localparam int MODE_ABS    = 0;
  localparam int MODE_ONCE   = 1;
  localparam int MODE_LATCH  = 2;
  localparam int MODE_LOCREQ = 3;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_ONE = 34'sd652032874;
  localparam logic signed [32:0] PHASE_QTR  = 33'sd1073741824;
  localparam logic signed [32:0] PHASE_HALF = 33'sd2147483648;

  typedef struct packed {
    logic start;
    logic done;
  } cordic_ctl_t;

  function automatic logic signed [32:0] atan_lut(input logic [4:0] idx);
    logic signed [32:0] v;
    unique case (idx)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamps a signed cell index to [0, hi] and keeps the field's nine bits.
  function automatic logic [8:0] clamp_cell(input logic signed [37:0] v,
                                            input logic signed [37:0] hi);
    logic signed [37:0] r;
    if (v < 38'sd0) begin
      r = 38'sd0;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[8:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/pgg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_if: channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pgg_in_if
  import pgg_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pgg_out_if
  import pgg_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pgg_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== design/pgg_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_cordic: iterative cosine and sine
// Rotation-mode CORDIC, one micro-rotation per cycle over CORDIC_STEPS steps.
// ----------------------------------------------------------------------------
module pgg_cordic
  import pgg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] heading,
  output      logic               done,
  output      logic signed [33:0] cos_out,
  output      logic signed [33:0] sin_out
);

  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic [4:0]         i_r;
  logic               busy_r, neg_r, done_r;
  logic signed [32:0] z0;
  logic signed [33:0] dx, dy;

  assign z0 = {heading[15], heading, 16'h0000};
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == 5'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_ONE;
      y_r <= '0;
      i_r <= '0;
      // Fold the phase into the right half plane; results are negated later.
      if (z0 > PHASE_QTR) begin
        z_r   <= z0 - PHASE_HALF;
        neg_r <= 1'b1;
      end else if (z0 < -PHASE_QTR) begin
        z_r   <= z0 + PHASE_HALF;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z0;
        neg_r <= 1'b0;
      end
    end else if (busy_r) begin
      i_r <= i_r + 5'd1;
      if (z_r >= 33'sd0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_lut(i_r);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_lut(i_r);
      end
    end
  end

  assign done    = done_r;
  assign cos_out = neg_r ? -x_r : x_r;
  assign sin_out = neg_r ? -y_r : y_r;

endmodule
`default_nettype wire

// ===== design/pgg_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_mul: shared signed multiplier
// One 34 by 34 signed product with a registered output.
// ----------------------------------------------------------------------------
module pgg_mul
  import pgg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [33:0] op_a,
  input  wire logic signed [33:0] op_b,
  output      logic signed [67:0] prod
);

  logic signed [67:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ===== design/pose_goal_gate_and_grid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pose_goal_gate_and_grid: pose gate, goal generator and grid mapper
// A valid result with a new relative goal takes the 24-step CORDIC plus eight
// multiplier passes; otherwise four passes. One item is processed at a time: a
// passing pose also waits on the result sink, and gated poses and replan requests
// are taken in IDLE without starting the sequencer.
// Synchronous active-low reset restores register defaults and clears the sequencer,
// gate, goal and result-valid state; datapath registers are not reset.
module pose_goal_gate_and_grid
  import pgg_pkg::*;
#(
  parameter int GRID_COLS      = 400,
  parameter int GRID_ROWS      = 400,
  parameter int MAX_LOST_COUNT = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pgg_in_if.sink    in_chan,
  pgg_out_if.source out_chan,
  pgg_cfg_if.sink   cfg_chan
);

  localparam logic signed [37:0] X_HI = 38'(GRID_COLS - 1);
  localparam logic signed [37:0] Y_HI = 38'(GRID_ROWS - 1);

  // Configuration registers
  logic [25:0]        cpm_r;
  logic signed [31:0] org_x_r, org_y_r, goal_fx_r, goal_ly_r;
  logic signed [15:0] abs_h_r;
  logic [3:0]         mode_r;
  logic [15:0]        intvl_r;

  // Gate and goal state
  logic               sent_once_r, replan_r, goal_held_r;
  logic signed [31:0] held_x_r, held_y_r;
  logic signed [15:0] held_h_r;
  logic [31:0]        last_time_r;

  // Item working registers
  state_t             state_r, state_nxt;
  logic signed [31:0] px_r, py_r;
  logic               abs_r;
  mul_op_t            op_r;
  logic               phase_r;
  logic signed [67:0] acc_r;
  logic [8:0]         sx_r, sy_r, gx_r, gy_r;
  out_item_t          out_r;
  logic               out_valid_r;

  // Shared units
  cordic_ctl_t        cctl;
  logic signed [33:0] cos_w, sin_w, mul_a, mul_b;
  logic signed [67:0] prod;

  logic accept, pass, need_goal, start_rel, load_out;
  logic blk_once, blk_int, blk_loc;
  logic [31:0] dt;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r     <= 26'd1310720;
      org_x_r   <= -32'sd655360;
      org_y_r   <= -32'sd655360;
      goal_fx_r <= 32'sd19661;
      goal_ly_r <= 32'sd0;
      abs_h_r   <= 16'sd0;
      mode_r    <= 4'd6;
      intvl_r   <= 16'd1000;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_CPM:    cpm_r     <= cfg_chan.wdata[25:0];
        CFG_ORG_X:  org_x_r   <= cfg_chan.wdata;
        CFG_ORG_Y:  org_y_r   <= cfg_chan.wdata;
        CFG_GOAL_X: goal_fx_r <= cfg_chan.wdata;
        CFG_GOAL_Y: goal_ly_r <= cfg_chan.wdata;
        CFG_ABS_H:  abs_h_r   <= cfg_chan.wdata[15:0];
        CFG_MODE:   mode_r    <= cfg_chan.wdata[3:0];
        CFG_INTVL:  intvl_r   <= cfg_chan.wdata[15:0];
        default:    ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept = in_chan.valid && in_chan.ready;

  assign dt       = in_chan.data.time_ms - last_time_r;
  assign blk_once = sent_once_r && mode_r[MODE_ONCE] && !replan_r;
  assign blk_int  = !replan_r && !mode_r[MODE_ONCE] && sent_once_r && (dt < {16'h0, intvl_r});
  assign blk_loc  = mode_r[MODE_LOCREQ] && in_chan.data.loc_mode &&
                    (!in_chan.data.loc_matched || in_chan.data.loss_cnt > 8'(MAX_LOST_COUNT));
  assign pass      = accept && !in_chan.data.opcode && !blk_once && !blk_int && !blk_loc;
  assign need_goal = !goal_held_r || !mode_r[MODE_LATCH];
  assign start_rel = pass && need_goal && !mode_r[MODE_ABS];
  assign cctl.start = start_rel;

  pgg_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cctl.start),
    .heading (in_chan.data.pose_heading),
    .done    (cctl.done),
    .cos_out (cos_w),
    .sin_out (sin_w)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (op_r)
      OP_CF: begin mul_a = cos_w; mul_b = 34'(goal_fx_r); end
      OP_SL: begin mul_a = sin_w; mul_b = 34'(goal_ly_r); end
      OP_SF: begin mul_a = sin_w; mul_b = 34'(goal_fx_r); end
      OP_CL: begin mul_a = cos_w; mul_b = 34'(goal_ly_r); end
      OP_SX: begin mul_a = 34'(px_r) - 34'(org_x_r); mul_b = {8'h00, cpm_r}; end
      OP_SY: begin mul_a = 34'(py_r) - 34'(org_y_r); mul_b = {8'h00, cpm_r}; end
      OP_GX: begin mul_a = 34'(held_x_r) - 34'(org_x_r); mul_b = {8'h00, cpm_r}; end
      OP_GY: begin mul_a = 34'(held_y_r) - 34'(org_y_r); mul_b = {8'h00, cpm_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  pgg_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  logic signed [67:0] rot_sum, rot_sh;
  logic signed [37:0] cell_idx, cell_flip;
  assign rot_sum   = ((op_r == OP_SL) ? acc_r - prod : acc_r + prod) + 68'sd536870912;
  assign rot_sh    = rot_sum >>> 30;
  assign cell_idx  = 38'(prod >>> 32);
  assign cell_flip = Y_HI - cell_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start_rel) begin
          state_nxt = ST_CORDIC;
        end else if (pass) begin
          state_nxt = ST_MUL;
        end
      end
      ST_CORDIC: begin
        if (cctl.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (phase_r && op_r == OP_GY) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Gate and goal state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_once_r <= 1'b0;
      replan_r    <= 1'b0;
      goal_held_r <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_h_r    <= '0;
      last_time_r <= '0;
    end else begin
      if (accept && in_chan.data.opcode) begin
        replan_r <= 1'b1;
      end else if (pass) begin
        sent_once_r <= 1'b1;
        replan_r    <= 1'b0;
        last_time_r <= in_chan.data.time_ms;
        if (need_goal) begin
          goal_held_r <= 1'b1;
          if (mode_r[MODE_ABS]) begin
            held_x_r <= goal_fx_r;
            held_y_r <= goal_ly_r;
            held_h_r <= abs_h_r;
          end else begin
            held_h_r <= in_chan.data.pose_heading;
          end
        end
      end
      if (state_r == ST_MUL && phase_r && op_r == OP_SL) begin
        held_x_r <= sat32(40'(rot_sh) + 40'(px_r));
      end
      if (state_r == ST_MUL && phase_r && op_r == OP_CL) begin
        held_y_r <= sat32(40'(rot_sh) + 40'(py_r));
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      op_r    <= OP_CF;
    end else if (pass) begin
      phase_r <= 1'b0;
      op_r    <= start_rel ? OP_CF : OP_SX;
    end else if (state_r == ST_MUL) begin
      phase_r <= !phase_r;
      if (phase_r) begin
        op_r <= mul_op_t'(op_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pass) begin
      px_r  <= in_chan.data.pose_x;
      py_r  <= in_chan.data.pose_y;
      abs_r <= mode_r[MODE_ABS];
    end
    if (state_r == ST_MUL && phase_r) begin
      unique case (op_r)
        OP_CF, OP_SF: acc_r <= prod;
        OP_SX: sx_r <= clamp_cell(cell_idx, X_HI);
        OP_SY: sy_r <= clamp_cell(cell_flip, Y_HI);
        OP_GX: gx_r <= clamp_cell(cell_idx, X_HI);
        OP_GY: gy_r <= clamp_cell(cell_flip, Y_HI);
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.start_cell_x  <= sx_r;
      out_r.start_cell_y  <= sy_r;
      out_r.goal_cell_x   <= gx_r;
      out_r.goal_cell_y   <= gy_r;
      out_r.goal_world_x  <= held_x_r;
      out_r.goal_world_y  <= held_y_r;
      out_r.goal_heading  <= held_h_r;
      out_r.goal_absolute <= abs_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

endmodule
`default_nettype wire

// ===== verif/pose_goal_gate_and_grid_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_goal_gate_and_grid_tb: goal gate and grid mapper testbench
// Drives pose events and replan requests with random idling on both channels,
// predicts the gated goal and grid cells in software and checks every result.
// ----------------------------------------------------------------------------
module pose_goal_gate_and_grid_tb;
  import pgg_pkg::*;

  localparam int MAP_W = 400;
  localparam int MAP_H = 400;
  localparam int MAX_LOST = 0;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  pgg_in_if  in_chan ();
  pgg_out_if out_chan ();
  pgg_cfg_if cfg_chan ();

  pose_goal_gate_and_grid #(
    .GRID_COLS(MAP_W), .GRID_ROWS(MAP_H), .MAX_LOST_COUNT(MAX_LOST)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan.sink), .out_chan(out_chan.source), .cfg_chan(cfg_chan.sink)
  );

  bit quiet_phase;
  int idle_cycles;
  int report_count;

  // Model copies of the registers and gate state.
  logic [25:0] m_cpm;
  logic signed [31:0] m_org_x, m_org_y, m_goal_x, m_goal_y;
  logic signed [15:0] m_abs_h;
  logic [3:0] m_mode;
  logic [15:0] m_intvl;
  bit m_sent, m_replan, m_held;
  logic signed [31:0] m_hx, m_hy;
  logic signed [15:0] m_hh;
  logic [31:0] m_last_time;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    report_count++;
  endtask

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void rotate_unit(longint heading, output longint c, output longint s);
    longint z, x, y, dx, dy, atan_v;
    bit neg;
    z = heading * 65536;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31); neg = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31); neg = 1;
    end
    for (int i = 0; i < 24; i++) begin
      case (i)
        0: atan_v = 536870912;  1: atan_v = 316933406; 2: atan_v = 167458907;
        3: atan_v = 85004756;   4: atan_v = 42667331;  5: atan_v = 21354465;
        6: atan_v = 10679838;   7: atan_v = 5340245;   8: atan_v = 2670163;
        9: atan_v = 1335087;    10: atan_v = 667544;   11: atan_v = 333772;
        12: atan_v = 166886;    13: atan_v = 83443;    14: atan_v = 41722;
        15: atan_v = 20861;     16: atan_v = 10430;    17: atan_v = 5215;
        18: atan_v = 2608;      19: atan_v = 1304;     20: atan_v = 652;
        21: atan_v = 326;       22: atan_v = 163;      default: atan_v = 81;
      endcase
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_v;
      end else begin
        x += dx; y -= dy; z += atan_v;
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint cell_of(longint w, longint org);
    longint d;
    d = w - org;
    return fshr(d * longint'(m_cpm), 32);
  endfunction

  function automatic logic [8:0] clip_cell(longint v, longint hi);
    longint r;
    r = (v < 0) ? 0 : (v > hi) ? hi : v;
    return r[8:0];
  endfunction

  function automatic void reset_model();
    m_cpm = 26'd1310720; m_org_x = -32'sd655360; m_org_y = -32'sd655360;
    m_goal_x = 32'sd19661; m_goal_y = 0; m_abs_h = 0; m_mode = 4'd6; m_intvl = 16'd1000;
    m_sent = 0; m_replan = 0; m_held = 0; m_hx = 0; m_hy = 0; m_hh = 0; m_last_time = 0;
  endfunction

  // Updates the model for one accepted transaction; returns 1 when a result is due.
  function automatic bit predict_goal(in_item_t it, output out_item_t r);
    longint c, s;
    bit once;
    logic [31:0] elapsed;
    r = '0;
    once = m_mode[MODE_ONCE];
    if (it.opcode) begin
      m_replan = 1;
      return 0;
    end
    if (m_sent && once && !m_replan) return 0;
    elapsed = it.time_ms - m_last_time;
    if (!m_replan && !once && m_sent && elapsed < {16'd0, m_intvl}) return 0;
    if (m_mode[MODE_LOCREQ] && it.loc_mode &&
        (!it.loc_matched || it.loss_cnt > MAX_LOST)) return 0;
    if (!m_held || !m_mode[MODE_LATCH]) begin
      if (m_mode[MODE_ABS]) begin
        m_hx = m_goal_x; m_hy = m_goal_y; m_hh = m_abs_h;
      end else begin
        rotate_unit(longint'(it.pose_heading), c, s);
        m_hx = clip32(longint'(it.pose_x) + fshr(c * longint'(m_goal_x)
               - s * longint'(m_goal_y) + (64'sd1 <<< 29), 30));
        m_hy = clip32(longint'(it.pose_y) + fshr(s * longint'(m_goal_x)
               + c * longint'(m_goal_y) + (64'sd1 <<< 29), 30));
        m_hh = it.pose_heading;
      end
      m_held = 1;
    end
    r.start_cell_x = clip_cell(cell_of(it.pose_x, m_org_x), MAP_W - 1);
    r.start_cell_y = clip_cell(MAP_H - 1 - cell_of(it.pose_y, m_org_y), MAP_H - 1);
    r.goal_cell_x = clip_cell(cell_of(m_hx, m_org_x), MAP_W - 1);
    r.goal_cell_y = clip_cell(MAP_H - 1 - cell_of(m_hy, m_org_y), MAP_H - 1);
    r.goal_world_x = m_hx;
    r.goal_world_y = m_hy;
    r.goal_heading = m_hh;
    r.goal_absolute = m_mode[MODE_ABS];
    m_sent = 1; m_replan = 0; m_last_time = it.time_ms;
    return 1;
  endfunction

  // Expected goal and cell results, checked in order.
  class goal_scoreboard;
    out_item_t pending_goals[$];

    function void note_input(in_item_t it);
      out_item_t exp_item;
      if (predict_goal(it, exp_item)) pending_goals.push_back(exp_item);
    endfunction

    task check_goal(out_item_t got);
      out_item_t exp_item;
      if (pending_goals.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      exp_item = pending_goals.pop_front();
      if (got.start_cell_x !== exp_item.start_cell_x ||
          got.start_cell_y !== exp_item.start_cell_y ||
          got.goal_cell_x !== exp_item.goal_cell_x ||
          got.goal_cell_y !== exp_item.goal_cell_y ||
          got.goal_world_x !== exp_item.goal_world_x ||
          got.goal_world_y !== exp_item.goal_world_y ||
          got.goal_heading !== exp_item.goal_heading ||
          got.goal_absolute !== exp_item.goal_absolute) begin
        report_mismatch($sformatf("got %h expected %h", got, exp_item));
      end
    endtask
  endclass

  goal_scoreboard board;

  // An idle burst drops valid first; the held transaction is otherwise replaced.
  task automatic random_gap();
    int n;
    if (!quiet_phase && $urandom_range(3) == 0) begin
      n = $urandom_range(7, 1);
      in_chan.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(in_item_t it);
    random_gap();
    in_chan.valid <= 1;
    in_chan.data <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_chan.valid <= 1;
    cfg_chan.index <= idx;
    cfg_chan.wdata <= v;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 0;
    case (idx)
      CFG_CPM:    m_cpm = v[25:0];
      CFG_ORG_X:  m_org_x = v;
      CFG_ORG_Y:  m_org_y = v;
      CFG_GOAL_X: m_goal_x = v;
      CFG_GOAL_Y: m_goal_y = v;
      CFG_ABS_H:  m_abs_h = v[15:0];
      CFG_MODE:   m_mode = v[3:0];
      default:    m_intvl = v[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 0;
    while (board.pending_goals.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic in_item_t pose_item(logic [31:0] t);
    in_item_t it;
    it.opcode = 0;
    it.time_ms = t;
    it.pose_x = $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000) - 700000;
    it.pose_y = $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000) - 700000;
    it.pose_heading = 16'($urandom);
    it.loc_mode = 1'($urandom);
    it.loc_matched = $urandom_range(3) != 0;
    it.loss_cnt = $urandom_range(3) == 0 ? 8'($urandom) : 8'd0;
    return it;
  endfunction

  // Receiver with random stalls; results are checked at acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) board.check_goal(out_chan.data);
      if (quiet_phase) out_chan.ready <= 1;
      else out_chan.ready <= ($urandom_range(4) != 0);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    logic [31:0] now;
    board = new();
    quiet_phase = 0;
    report_count = 0;
    rst_n = 0;
    in_chan.valid = 0;
    in_chan.data = '0;
    cfg_chan.valid = 0;
    cfg_chan.index = CFG_CPM;
    cfg_chan.wdata = 0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: defaults (send once, latch), replan, then extremes.
    now = 0;
    it = pose_item(0);
    it.pose_x = 32'sh7FFFFFFF; it.pose_y = 32'sh80000000; it.pose_heading = 16'sh7FFF;
    send_item(it);
    send_item(pose_item(5));
    it.opcode = 1; send_item(it);
    it = pose_item(9); it.pose_heading = 16'sh8000; send_item(it);
    drain();
    write_reg(CFG_MODE, 32'h00000008);
    write_reg(CFG_INTVL, 32'h0000FFFF);
    write_reg(CFG_GOAL_X, 32'h7FFFFFFF);
    write_reg(CFG_GOAL_Y, 32'h80000000);
    write_reg(CFG_CPM, 32'h03FFFFFF);
    it = pose_item(100); it.loc_mode = 1; it.loc_matched = 0; send_item(it);
    it.loc_matched = 1; it.loss_cnt = 8'hFF; send_item(it);
    it.loss_cnt = 0; it.pose_heading = 16'sh4000; send_item(it);
    it.time_ms = 200; send_item(it);
    it.time_ms = 100 + 16'hFFFF; send_item(it);
    it.time_ms = 32'hFFFFFFFF; it.pose_heading = -16'sh4000; send_item(it);
    drain();
    write_reg(CFG_MODE, 32'h00000001);
    write_reg(CFG_CPM, 32'h00000000);
    write_reg(CFG_ABS_H, 32'h00008000);
    write_reg(CFG_ORG_X, 32'h7FFFFFFF);
    write_reg(CFG_ORG_Y, 32'h80000000);
    write_reg(CFG_INTVL, 32'h00000000);
    send_item(pose_item(3));
    send_item(pose_item(3));
    drain();

    // Random phases, each with a fresh setting.
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(CFG_CPM, ph == 1 ? 32'h03FFFFFF : $urandom_range(3000000));
      write_reg(CFG_ORG_X, $urandom_range(1500000) - 1000000);
      write_reg(CFG_ORG_Y, $urandom_range(1500000) - 1000000);
      write_reg(CFG_GOAL_X, ph == 2 ? 32'h80000000 : $urandom_range(400000) - 200000);
      write_reg(CFG_GOAL_Y, ph == 2 ? 32'h7FFFFFFF : $urandom_range(400000) - 200000);
      write_reg(CFG_ABS_H, $urandom);
      write_reg(CFG_MODE, ph < 4 ? 32'h00000000 : $urandom_range(15));
      write_reg(CFG_INTVL, ph == 3 ? 32'h0000FFFF : $urandom_range(200));
      quiet_phase = (ph >= 12);
      now = $urandom;
      for (int k = 0; k < 75; k++) begin
        now += $urandom_range(150);
        it = pose_item(now);
        if ($urandom_range(7) == 0) it.opcode = 1;
        send_item(it);
      end
      drain();
    end

    if (report_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== pose_goal_gate_and_grid.f =====
design/pgg_pkg.sv
design/pgg_if.sv
design/pgg_cordic.sv
design/pgg_mul.sv
design/pose_goal_gate_and_grid.sv
verif/pose_goal_gate_and_grid_tb.sv
